// ===== src/vdm_pkg.sv =====
// ----------------------------------------------------------------------------
// vdm_pkg
// Shared types, constants and helpers for the vector distance metrics block.
// ----------------------------------------------------------------------------
package vdm_pkg;

  localparam int unsigned AccW      = 48;
  localparam int unsigned ProdW     = 34;
  localparam int unsigned RootW     = 24;
  localparam int unsigned NumW      = AccW + 14;
  localparam int unsigned FifoDepth = 2;
  localparam logic [14:0] OneQ14    = 15'd16384;

  typedef enum logic [1:0] {
    MODE_EUCLID = 2'd0,
    MODE_COSINE = 2'd1,
    MODE_DOT    = 2'd2,
    MODE_RSVD   = 2'd3
  } vdm_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOTA_GO,
    S_ROOTA,
    S_ROOTB_GO,
    S_ROOTB,
    S_MUL,
    S_DIV,
    S_OUT
  } vdm_state_e;

  // one finished vector pair, handed from the accumulator to the back end
  typedef struct packed {
    vdm_mode_e          mode;
    logic signed [47:0] dot;
    logic signed [47:0] xsq;
    logic signed [47:0] ysq;
    logic signed [47:0] dsq;
  } vdm_entry_t;

  // saturating accumulate at the 48-bit signed limits
  function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                  input logic signed [33:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s[48] != s[47]) begin
      sat_add = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sat_add = s[47:0];
    end
  endfunction

endpackage

// ===== src/vdm_fifo.sv =====
// ----------------------------------------------------------------------------
// vdm_fifo
// Short queue of finished sums between the accumulator and the back end.
// ----------------------------------------------------------------------------
module vdm_fifo
  import vdm_pkg::*;
#(
  parameter int unsigned DEPTH = FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  vdm_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output vdm_entry_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  vdm_entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]         cnt_q, cnt_d;

  assign full_o     = (cnt_q == (PtrW+1)'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(DEPTH))
    else $error("queue fill count beyond depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i)
    else $error("push into full queue");
`endif

endmodule

// ===== src/vdm_front.sv =====
// ----------------------------------------------------------------------------
// vdm_front
// Accepts element pairs, forms the products and keeps the four running sums.
// ----------------------------------------------------------------------------
module vdm_front
  import vdm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic signed [15:0] x_elem_i,
  input  logic signed [15:0] y_elem_i,
  input  logic               last_elem_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output vdm_entry_t         q_data_o
);

  vdm_mode_e          mode_q;
  logic               p_valid_q, p_last_q;
  logic signed [33:0] pxy_q, pxx_q, pyy_q, pdd_q;
  logic signed [47:0] dot_q, xsq_q, ysq_q, dsq_q;
  logic signed [47:0] dot_n, xsq_n, ysq_n, dsq_n;
  logic signed [16:0] diff;
  logic               p_go, accept;

  assign p_go       = p_valid_q && !(p_last_q && q_full_i);
  assign s_tready_o = !p_valid_q || p_go;
  assign accept     = s_tvalid_i && s_tready_o;
  assign diff       = 17'(x_elem_i) - 17'(y_elem_i);

  assign dot_n = sat_add(dot_q, pxy_q);
  assign xsq_n = sat_add(xsq_q, pxx_q);
  assign ysq_n = sat_add(ysq_q, pyy_q);
  assign dsq_n = sat_add(dsq_q, pdd_q);

  assign q_push_o = p_go && p_last_q;
  assign q_data_o = '{mode: mode_q, dot: dot_n, xsq: xsq_n, ysq: ysq_n, dsq: dsq_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_EUCLID;
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
      dot_q     <= '0;
      xsq_q     <= '0;
      ysq_q     <= '0;
      dsq_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= vdm_mode_e'(cfg_wdata_i);
      end
      if (s_tready_o) begin
        p_valid_q <= s_tvalid_i;
      end
      if (accept) begin
        p_last_q <= last_elem_i;
      end
      if (p_go) begin
        if (p_last_q) begin
          dot_q <= '0;
          xsq_q <= '0;
          ysq_q <= '0;
          dsq_q <= '0;
        end else begin
          dot_q <= dot_n;
          xsq_q <= xsq_n;
          ysq_q <= ysq_n;
          dsq_q <= dsq_n;
        end
      end
    end
  end

  // product stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pxy_q <= 34'(x_elem_i * y_elem_i);
      pxx_q <= 34'(x_elem_i * x_elem_i);
      pyy_q <= 34'(y_elem_i * y_elem_i);
      pdd_q <= 34'(diff * diff);
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_go && p_last_q |=> dot_q == '0 && dsq_q == '0)
    else $error("sums not cleared after last pair");
`endif

endmodule

// ===== src/vdm_isqrt.sv =====
// ----------------------------------------------------------------------------
// vdm_isqrt
// Integer square root of a 48-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vdm_isqrt
  import vdm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AccW-1:0]  op_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic [AccW-1:0] n_q, root_q, bit_q, trial;
  logic            busy_q, done_q;

  assign trial  = root_q + bit_q;
  assign done_o = done_q;
  assign root_o = root_q[RootW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
      root_q <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        n_q    <= op_i;
        root_q <= '0;
        bit_q  <= AccW'(1) << (AccW - 2);
      end else if (busy_q) begin
        if (n_q >= trial) begin
          n_q    <= n_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/vdm_back.sv =====
// ----------------------------------------------------------------------------
// vdm_back
// Takes finished sums from the queue and works out the selected metric.
// ----------------------------------------------------------------------------
module vdm_back
  import vdm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  vdm_entry_t        q_data_i,
  output logic              q_pop_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [AccW-1:0]   m_tdata_o,
  output logic              m_tuser_o
);

  vdm_state_e        state_q, state_d;
  vdm_entry_t        ent_q;
  logic [RootW-1:0]  nx_q, root;
  logic [AccW-1:0]   den_q, res_q, sq_op, dot_abs;
  logic [NumW-1:0]   num_q, quo_q;
  logic [AccW-1:0]   rem_q;
  logic [AccW:0]     trial;
  logic [5:0]        cnt_q;
  logic              zn_q, sq_start, sq_done, out_load, trial_ge;
  logic              m_valid_q, m_user_q;
  logic [AccW-1:0]   m_data_q, out_val, cos_val;
  logic [14:0]       mag;

  vdm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    (sq_op),
    .done_o  (sq_done),
    .root_o  (root)
  );

  // non-negative operand for the root unit
  always_comb begin
    if (state_q == S_ROOTB_GO) begin
      sq_op = ent_q.ysq[47] ? '0 : ent_q.ysq;
    end else if (ent_q.mode == MODE_COSINE) begin
      sq_op = ent_q.xsq[47] ? '0 : ent_q.xsq;
    end else begin
      sq_op = ent_q.dsq[47] ? '0 : ent_q.dsq;
    end
  end

  assign dot_abs  = ent_q.dot[47] ? AccW'(-ent_q.dot) : ent_q.dot;
  assign trial    = {rem_q, num_q[NumW-1]};
  assign trial_ge = (trial >= {1'b0, den_q});
  assign mag      = (quo_q > NumW'(OneQ14)) ? OneQ14 : quo_q[14:0];
  assign cos_val  = ent_q.dot[47] ? AccW'(OneQ14) + AccW'(mag)
                                  : AccW'(OneQ14) - AccW'(mag);
  assign out_val  = (ent_q.mode == MODE_COSINE && !zn_q) ? cos_val : res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          unique case (q_data_i.mode)
            MODE_EUCLID, MODE_COSINE: state_d = S_ROOTA_GO;
            MODE_DOT, MODE_RSVD:      state_d = S_OUT;
            default:                  state_d = S_OUT;
          endcase
        end
      end
      S_ROOTA_GO: state_d = S_ROOTA;
      S_ROOTA: begin
        if (sq_done) begin
          state_d = (ent_q.mode == MODE_COSINE) ? S_ROOTB_GO : S_OUT;
        end
      end
      S_ROOTB_GO: state_d = S_ROOTB;
      S_ROOTB: begin
        if (sq_done) begin
          state_d = (nx_q == '0 || root == '0) ? S_OUT : S_MUL;
        end
      end
      S_MUL:   state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
    sq_start = (state_q == S_ROOTA_GO) || (state_q == S_ROOTB_GO);
    out_load = (state_q == S_OUT) && (!m_valid_q || m_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        ent_q <= q_data_i;
        zn_q  <= 1'b0;
        res_q <= (q_data_i.mode == MODE_DOT) ? q_data_i.dot : '0;
      end
      S_ROOTA: begin
        if (sq_done) begin
          nx_q  <= root;
          res_q <= AccW'(root);
        end
      end
      S_ROOTB: begin
        if (sq_done && (nx_q == '0 || root == '0)) begin
          zn_q  <= 1'b1;
          res_q <= '0;
        end
        den_q <= AccW'(nx_q * root);
      end
      S_MUL: begin
        num_q <= {dot_abs, 14'd0};
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= 6'(NumW - 1);
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        rem_q <= trial_ge ? AccW'(trial - {1'b0, den_q}) : trial[AccW-1:0];
        num_q <= num_q << 1;
        quo_q <= {quo_q[NumW-2:0], trial_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      m_data_q <= out_val;
      m_user_q <= zn_q;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> den_q != '0)
    else $error("division by zero norm");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i && state_q == S_IDLE)
    else $error("pop outside idle");
`endif

endmodule

// ===== src/vector_distance_metrics.sv =====
// ----------------------------------------------------------------------------
// vector_distance_metrics
// Streaming Euclidean, cosine and dot-product metrics over Q8.8 vectors.
// ----------------------------------------------------------------------------
// Element pairs are taken one a cycle while the input is not stalled, and folded
// into four saturating 48-bit sums after a product stage. A request marked tlast
// closes the vectors and its sums go into a short queue. After taking the sums
// off the queue, the back end goes straight to the output register for the dot
// product or a reserved mode, runs a 24-step square root for the Euclidean
// distance, and runs two square roots, a multiply and a 62-step restoring
// division for the cosine distance (the last two skipped if a norm is zero),
// plus any wait on m_axis_tready. Input stalls only when the queue is full at
// the end of a vector, so short vectors back to back are limited by the back end.
module vector_distance_metrics
  import vdm_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_elem [15:0], y_elem [31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // metric_value [47:0]
  output logic        m_axis_tuser    // zero_norm [0]
);

  logic       q_push, q_full, q_pop, q_empty;
  vdm_entry_t q_wdata, q_rdata;

  vdm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .x_elem_i    (s_axis_tdata[15:0]),
    .y_elem_i    (s_axis_tdata[31:16]),
    .last_elem_i (s_axis_tlast),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  vdm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  vdm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

// ===== dv/tb_vector_distance_metrics.sv =====
// ----------------------------------------------------------------------------
// tb_vector_distance_metrics
// Self-checking bench for the streaming vector distance metrics block.
// ----------------------------------------------------------------------------
// Element pairs are streamed with random gaps, vectors are closed with tlast
// and each metric is predicted in the bench and compared in arrival order.
// Mode changes happen only with the block idle.
`timescale 1ns / 100ps

module tb_vector_distance_metrics;
  import vdm_pkg::*;

  localparam int unsigned WdogLimit = 20000;
  localparam int unsigned DrainWait = 300;

  typedef struct packed {
    logic signed [47:0] value;
    logic               zero_norm;
  } metric_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  vector_distance_metrics u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  vdm_mode_e           cur_mode;
  logic signed [63:0]  dot_acc, xsq_acc, ysq_acc, dsq_acc;
  metric_t             metric_q[$];

  int unsigned n_err = 0;
  int unsigned n_req = 0;
  int unsigned n_vec = 0;
  int unsigned n_res = 0;
  int unsigned stall_left = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int unsigned rx_hold = 0;
  int unsigned idle_cycles = 0;

  function automatic logic signed [63:0] clamp48(input logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    hi = 64'sh7FFF_FFFF_FFFF;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic [63:0] root_floor(input logic signed [63:0] v);
    logic [63:0] n, r, b;
    n = (v < 0) ? 64'd0 : 64'(v);
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // fold one element pair in; closes the vectors and queues a metric on last
  task automatic predict_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                              input bit last);
    logic signed [63:0] xs, ys, d, q, den;
    logic [63:0] nx, ny;
    metric_t m;
    xs = x;
    ys = y;
    d = xs - ys;
    dot_acc = clamp48(dot_acc + xs * ys);
    xsq_acc = clamp48(xsq_acc + xs * xs);
    ysq_acc = clamp48(ysq_acc + ys * ys);
    dsq_acc = clamp48(dsq_acc + d * d);
    if (!last) return;
    m = '0;
    case (cur_mode)
      MODE_EUCLID: m.value = 48'(root_floor(dsq_acc));
      MODE_COSINE: begin
        nx = root_floor(xsq_acc);
        ny = root_floor(ysq_acc);
        if (nx == 0 || ny == 0) begin
          m.zero_norm = 1'b1;
        end else begin
          den = $signed(nx * ny);
          q = (dot_acc * 64'sd16384) / den;
          if (q > 64'sd16384) q = 64'sd16384;
          if (q < -64'sd16384) q = -64'sd16384;
          m.value = 48'(64'sd16384 - q);
        end
      end
      MODE_DOT: m.value = 48'(dot_acc);
      default: m.value = '0;
    endcase
    metric_q.push_back(m);
    dot_acc = 0;
    xsq_acc = 0;
    ysq_acc = 0;
    dsq_acc = 0;
    n_vec++;
  endtask

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] exp);
    n_err++;
    if (n_err <= 30) $display("mismatch %s: got %0h expected %0h", what, got, exp);
  endtask

  // send one request, with an optional random gap in front
  task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input bit last);
    int unsigned gap;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pair(x, y, last);
    n_req++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (metric_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_mode(input vdm_mode_e m);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cur_mode = m;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_pair(16'h7FFF, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_pair(16'h0000, 16'h0100, 1'b1);
    send_pair(16'h0100, 16'h0100, 1'b0);
    send_pair(16'hFF00, 16'h0200, 1'b1);
    send_pair(16'hFFFF, 16'h0001, 1'b1);
  endtask

  task automatic test_all_modes();
    for (int m = 0; m < 4; m++) begin
      set_mode(vdm_mode_e'(m));
      test_directed();
      send_pair(16'h0000, 16'h0000, 1'b1);
    end
  endtask

  task automatic test_random(input int unsigned n_pairs);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_pairs) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      for (int unsigned i = 1; i <= len; i++) send_pair(rand_elem(), rand_elem(), i == len);
      sent += len;
      if (tx_gaps && $urandom_range(0, 30) == 0) set_mode(vdm_mode_e'($urandom_range(0, 3)));
    end
  endtask

  // long receiver hold-off while short vectors pile up on the input
  task automatic test_backpressure();
    rx_hold = 400;
    for (int i = 0; i < 40; i++) send_pair(rand_elem(), rand_elem(), 1'b1);
  endtask

  // result side: random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    metric_t exp_m;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_res++;
      if (metric_q.size() == 0) begin
        report("unexpected metric", m_axis_tdata, '0);
      end else begin
        exp_m = metric_q.pop_front();
        if (m_axis_tdata !== exp_m.value) report("metric_value", m_axis_tdata, exp_m.value);
        if (m_axis_tuser !== exp_m.zero_norm)
          report("zero_norm", 48'(m_axis_tuser), 48'(exp_m.zero_norm));
      end
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WdogLimit) begin
        $display("watchdog expired");
        $display("tb_vector_distance_metrics failed");
        $finish;
      end
    end
  end

  initial begin
    cur_mode = MODE_EUCLID;
    dot_acc = 0;
    xsq_acc = 0;
    ysq_acc = 0;
    dsq_acc = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_all_modes();
    test_backpressure();
    set_mode(MODE_COSINE);
    test_random(1100);
    set_mode(MODE_EUCLID);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random(300);
    wait_idle();
    $display("%0d element requests, %0d vectors closed, %0d metrics checked", n_req, n_vec,
             n_res);
    $display("all modes, extreme elements, zero vectors and output back-pressure exercised");
    if (n_err == 0) begin
      $display("tb_vector_distance_metrics passed");
    end else begin
      $display("tb_vector_distance_metrics failed");
    end
    $finish;
  end

endmodule
